[hdl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/stbs_pkg.sv]
package stbs_pkg;

    localparam int ACTION_W = 2;
    localparam int WIDX_W   = 10;
    localparam int RANGE_W  = 11;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 11;

    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOWER = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_UPPER = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] position;
    } stbs_result_t;

endpackage

[hdl/stbs_ram.sv]
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/stbs_search.sv]
module stbs_search
    import stbs_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ACTION_W-1:0]      s_action,
    input  logic [WIDX_W-1:0]        s_write_index,
    input  logic [RANGE_W-1:0]       s_range_start,
    input  logic [RANGE_W-1:0]       s_range_end,
    input  logic signed [KEY_W-1:0]  s_key,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic [VALUE_WIDTH-1:0]   ram_wdata,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  logic [VALUE_WIDTH-1:0]   ram_rdata,
    output stbs_result_t             result,
    input  logic                     result_ready
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(DEPTH + 1);
    localparam int RW = (AW > WIDX_W + 1) ? AW : WIDX_W + 1;
    localparam int CW = (IW > RANGE_W) ? IW : RANGE_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRITE  = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    function automatic logic [AW-1:0] wrap_index(input logic [WIDX_W-1:0] idx);
        logic [RW-1:0] v;
        v = RW'(idx);
        for (int k = WIDX_W - 1; k >= 0; k--) begin
            if (longint'(v) >= (longint'(DEPTH) << k)) begin
                v = v - RW'(longint'(DEPTH) << k);
            end
        end
        return v[AW-1:0];
    endfunction

    function automatic logic [IW-1:0] clamp_bound(input logic [RANGE_W-1:0] r);
        logic [CW-1:0] w;
        w = CW'(r);
        if (w > CW'(DEPTH)) begin
            w = CW'(DEPTH);
        end
        return w[IW-1:0];
    endfunction

    function automatic logic [AW-1:0] midpoint(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[AW:1];
    endfunction

    logic [2:0]                    state_reg, state_next;
    logic [IW-1:0]                 lo_reg, lo_next;
    logic [IW-1:0]                 hi_reg, hi_next;
    logic [AW-1:0]                 mid_reg, mid_next;
    logic                          upper_reg, upper_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [AW-1:0]                 widx_reg, widx_next;

    logic signed [VALUE_WIDTH-1:0] entry;
    logic                          go_left;
    logic [IW-1:0]                 step_lo, step_hi;

    assign entry   = signed'(ram_rdata);
    assign go_left = upper_reg ? (entry > key_reg) : (entry >= key_reg);
    assign step_lo = go_left ? lo_reg : IW'(mid_reg) + IW'(1);
    assign step_hi = go_left ? IW'(mid_reg) : hi_reg;

    always_comb begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        upper_next = upper_reg;
        key_next   = key_reg;
        widx_next  = widx_reg;
        ram_raddr  = mid_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    key_next   = VALUE_WIDTH'(s_key);
                    widx_next  = wrap_index(s_write_index);
                    lo_next    = clamp_bound(s_range_start);
                    hi_next    = clamp_bound(s_range_end);
                    upper_next = (s_action == ACT_UPPER);
                    if (s_action == ACT_WRITE) begin
                        state_next = S_WRITE;
                    end else if (s_action == ACT_LOWER || s_action == ACT_UPPER) begin
                        state_next = S_START;
                    end
                end
            end
            S_WRITE: begin
                state_next = S_IDLE;
            end
            S_START: begin
                mid_next  = midpoint(lo_reg, hi_reg);
                ram_raddr = mid_next;
                if (lo_reg < hi_reg) begin
                    state_next = S_SEARCH;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SEARCH: begin
                lo_next   = step_lo;
                hi_next   = step_hi;
                mid_next  = midpoint(step_lo, step_hi);
                ram_raddr = mid_next;
                if (step_lo >= step_hi) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (result_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        upper_reg <= upper_next;
        key_reg   <= key_next;
        widx_reg  <= widx_next;
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign ram_we          = (state_reg == S_WRITE);
    assign ram_waddr       = widx_reg;
    assign ram_wdata       = key_reg;
    assign result.valid    = (state_reg == S_DONE);
    assign result.position = POS_W'(lo_reg);

endmodule

[hdl/sorted_table_bound_search_top.sv]
// A write beat passes through S_WRITE, where the table is written, then back to idle.
// A query runs S_START, S_SEARCH per bisection step, at most clog2(DEPTH + 1), S_DONE:
// one table RAM read per step, the next midpoint issued in the cycle the data returns.
// At most one beat is in work; a result waits in S_DONE, then in the output register.
// aresetn is synchronous and clears control state only; table contents are kept.
`include "assert_macros.svh"

module sorted_table_bound_search_top
    import stbs_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ACTION_W-1:0]     s_action,
    input  logic [WIDX_W-1:0]       s_write_index,
    input  logic [RANGE_W-1:0]      s_range_start,
    input  logic [RANGE_W-1:0]      s_range_end,
    input  logic signed [KEY_W-1:0] s_key,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [POS_W-1:0]        m_position
);

    localparam int AW = $clog2(DEPTH);

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    stbs_result_t           result;
    logic                   result_ready;

    logic             m_valid_reg, m_valid_next;
    logic [POS_W-1:0] m_position_reg, m_position_next;

    stbs_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    stbs_search #(
        .DEPTH      (DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_search (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_write_index(s_write_index),
        .s_range_start(s_range_start),
        .s_range_end  (s_range_end),
        .s_key        (s_key),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .result       (result),
        .result_ready (result_ready)
    );

    assign result_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_position_next = m_position_reg;
        if (result.valid && result_ready) begin
            m_valid_next    = 1'b1;
            m_position_next = result.position;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_position_reg <= m_position_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;

    `ASSERT_NEXT(a_result_waits, aclk, aresetn, result.valid && !result_ready, result.valid, "finished result dropped while output busy")
    `ASSERT_IMPLIES(a_idle_no_result, aclk, aresetn, s_ready, !result.valid, "result offered while idle")
    `ASSERT_IMPLIES(a_position_range, aclk, aresetn, result.valid, result.position <= DEPTH, "position beyond table depth")

endmodule
